@@ hdl/bfha_pkg.sv @@
// Package for the best-fit heap allocator: sizes, codes, table entry type.
// No dependencies.
package bfha_pkg;

    localparam int MAX_BLOCKS = 64;
    localparam int IDX_W = $clog2(MAX_BLOCKS);
    localparam int CNT_W = $clog2(MAX_BLOCKS + 1);
    localparam logic [15:0] HEADER = 16'd24;
    localparam logic [15:0] HEAP_RESET = 16'd10024;

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_FULL = 2'd1;
    localparam logic [1:0] ST_NONE = 2'd2;

    localparam logic FUNC_ALLOC = 1'b0;
    localparam logic FUNC_FREE  = 1'b1;

    typedef struct packed {
        logic [15:0] start;
        logic [15:0] size;
        logic        used;
    } blk_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_INIT,
        S_SCAN_RD,
        S_SCAN,
        S_DECIDE,
        S_UP_RD,
        S_UP_WR,
        S_SPLIT,
        S_NEXT_RD,
        S_NEXT,
        S_MERGE,
        S_DN_RD,
        S_DN_WR,
        S_DONE
    } state_t;

endpackage

@@ hdl/bfha_if.sv @@
// Valid/ready channel interfaces for the allocator's request and result.
// Depends on nothing.
interface bfha_req_if;
    logic        valid;
    logic        ready;
    logic        func;
    logic [15:0] request_bytes;
    logic [15:0] payload_offset;
    modport source (output valid, func, request_bytes, payload_offset, input ready);
    modport sink   (input valid, func, request_bytes, payload_offset, output ready);
endinterface

interface bfha_rsp_if;
    logic        valid;
    logic        ready;
    logic [1:0]  status;
    logic [15:0] granted_offset;
    modport source (output valid, status, granted_offset, input ready);
    modport sink   (input valid, status, granted_offset, output ready);
endinterface

@@ hdl/bfha_table_ram.sv @@
// Block table storage: one write port, one registered read port.
// Depends on bfha_pkg.
module bfha_table_ram (
    input  logic                      clk,
    input  logic                      we,
    input  logic [bfha_pkg::IDX_W-1:0] waddr,
    input  bfha_pkg::blk_t            wdata,
    input  logic [bfha_pkg::IDX_W-1:0] raddr,
    output bfha_pkg::blk_t            rdata
);
    import bfha_pkg::*;

    blk_t mem [MAX_BLOCKS];

    // write and registered read
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

@@ hdl/best_fit_heap_allocator_core.sv @@
// Top level of the best-fit heap allocator: sequencer plus block table memory.
// Depends on bfha_pkg, bfha_if.sv and bfha_table_ram.
//
//  channel   dir   transfer when          payload
//  req       in    req.valid & req.ready  func, request_bytes, payload_offset
//  rsp       out   rsp.valid & rsp.ready  status, granted_offset
//  cfg       in    cfg_we                 cfg_wdata (heap_bytes)
//
// Allocate scans every entry, one table read per entry, and when it splits a
// block it moves the entries above the best fit up to open a slot.
// Free scans until it finds a match, reads its successor if there is one,
// and when a merge removes entries it moves the entries above down.
// All table reads go through one registered-read memory port.
// Reset or a cfg write reinitializes the table (entry 0 only).
// req.ready is low while an item is in flight or its result is unclaimed.
module best_fit_heap_allocator_core (
    input  logic       clk,
    input  logic       rst_n,
    bfha_req_if.sink   req,
    bfha_rsp_if.source rsp,
    input  logic       cfg_we,
    input  logic [15:0] cfg_wdata
);
    import bfha_pkg::*;

    state_t state_reg, state_next;
    logic [15:0] heap_reg;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [CNT_W-1:0] idx_reg, idx_next;
    logic [CNT_W-1:0] best_reg, best_next;
    logic             found_reg, found_next;
    blk_t             best_blk_reg, best_blk_next;
    logic             func_reg;
    logic [15:0]      req_reg, off_reg;
    logic [1:0]       st_reg, st_next;
    logic [15:0]      gr_reg, gr_next;
    logic             rv_reg, rv_next;
    // merge bookkeeping: free neighbors of the freed entry
    blk_t             prev_reg, prev_next;
    logic             mrg_prev_reg, mrg_prev_next;
    logic             mrg_next_reg, mrg_next_next;

    logic             we;
    logic [IDX_W-1:0] waddr, raddr;
    blk_t             wdata, rdata;

    bfha_table_ram u_ram (
        .clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata)
    );

    logic [16:0] need;
    logic [16:0] diff;
    logic [15:0] remain;
    logic [15:0] top_start;
    logic [1:0]  gap;
    logic [CNT_W-1:0] src0;
    assign need = {1'b0, req_reg} + {1'b0, HEADER};
    assign diff = {1'b0, best_blk_reg.size} - {1'b0, req_reg};
    assign remain = best_blk_reg.size - need[15:0];
    assign top_start = best_blk_reg.start + remain;
    assign gap = {1'b0, mrg_prev_reg} + {1'b0, mrg_next_reg};
    assign src0 = best_reg + CNT_W'(1) + CNT_W'(mrg_next_reg);

    assign req.ready = (state_reg == S_IDLE) && !rv_reg;
    assign rsp.valid = rv_reg;
    assign rsp.status = st_reg;
    assign rsp.granted_offset = gr_reg;

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_INIT;
            heap_reg <= HEAP_RESET;
            cnt_reg <= CNT_W'(1);
            rv_reg <= 1'b0;
        end
        else
        begin
            state_reg <= cfg_we ? S_INIT : state_next;
            if (cfg_we)
            begin
                heap_reg <= cfg_wdata;
            end
            cnt_reg <= cnt_next;
            rv_reg <= rv_next;
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        idx_reg <= idx_next;
        best_reg <= best_next;
        found_reg <= found_next;
        best_blk_reg <= best_blk_next;
        st_reg <= st_next;
        gr_reg <= gr_next;
        prev_reg <= prev_next;
        mrg_prev_reg <= mrg_prev_next;
        mrg_next_reg <= mrg_next_next;
        if (req.valid && req.ready)
        begin
            func_reg <= req.func;
            req_reg <= req.request_bytes;
            off_reg <= req.payload_offset;
        end
    end

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        cnt_next = cnt_reg;
        idx_next = idx_reg;
        best_next = best_reg;
        found_next = found_reg;
        best_blk_next = best_blk_reg;
        st_next = st_reg;
        gr_next = gr_reg;
        rv_next = rv_reg;
        prev_next = prev_reg;
        mrg_prev_next = mrg_prev_reg;
        mrg_next_next = mrg_next_reg;
        we = 1'b0;
        waddr = '0;
        wdata = '0;
        raddr = idx_reg[IDX_W-1:0];
        if (rv_reg && rsp.ready)
        begin
            rv_next = 1'b0;
        end
        unique case (state_reg)
            S_INIT:
            begin
                we = 1'b1;
                wdata = '{start: 16'd0, size: heap_reg, used: 1'b0};
                cnt_next = CNT_W'(1);
                state_next = S_IDLE;
            end
            S_IDLE:
            begin
                if (req.valid && req.ready)
                begin
                    idx_next = '0;
                    found_next = 1'b0;
                    st_next = ST_OK;
                    gr_next = '0;
                    state_next = S_SCAN_RD;
                end
            end
            S_SCAN_RD:
            begin
                state_next = S_SCAN;
            end
            S_SCAN:
            begin
                // each entry is read in S_SCAN_RD and compared here
                if (func_reg == FUNC_ALLOC)
                begin
                    if (!rdata.used && {1'b0, rdata.size} >= need
                        && (!found_reg || rdata.size < best_blk_reg.size))
                    begin
                        found_next = 1'b1;
                        best_next = idx_reg;
                        best_blk_next = rdata;
                    end
                    if (idx_reg + CNT_W'(1) >= cnt_reg)
                    begin
                        state_next = S_DECIDE;
                    end
                    else
                    begin
                        idx_next = idx_reg + CNT_W'(1);
                        state_next = S_SCAN_RD;
                    end
                end
                else
                begin
                    if (rdata.used && off_reg >= HEADER
                        && rdata.start == off_reg - HEADER)
                    begin
                        found_next = 1'b1;
                        best_next = idx_reg;
                        best_blk_next = rdata;
                        state_next = S_DECIDE;
                    end
                    else if (idx_reg + CNT_W'(1) >= cnt_reg)
                    begin
                        state_next = S_DECIDE;
                    end
                    else
                    begin
                        prev_next = rdata;
                        idx_next = idx_reg + CNT_W'(1);
                        state_next = S_SCAN_RD;
                    end
                end
            end
            S_DECIDE:
            begin
                if (!found_reg)
                begin
                    st_next = (func_reg == FUNC_ALLOC) ? ST_FULL : ST_NONE;
                    state_next = S_DONE;
                end
                else if (func_reg == FUNC_ALLOC)
                begin
                    if (diff > 17'({HEADER, 1'b0}))
                    begin
                        if (cnt_reg >= CNT_W'(MAX_BLOCKS))
                        begin
                            st_next = ST_FULL;
                            state_next = S_DONE;
                        end
                        else
                        begin
                            // open a slot at best+1 by shifting up from the end
                            idx_next = cnt_reg;
                            state_next = S_UP_RD;
                        end
                    end
                    else if (best_blk_reg.start == 16'd0)
                    begin
                        st_next = ST_FULL;
                        state_next = S_DONE;
                    end
                    else
                    begin
                        we = 1'b1;
                        waddr = best_reg[IDX_W-1:0];
                        wdata = '{start: best_blk_reg.start, size: best_blk_reg.size,
                                  used: 1'b1};
                        gr_next = best_blk_reg.start + HEADER;
                        state_next = S_DONE;
                    end
                end
                else
                begin
                    // free: note a free predecessor, then look at the successor
                    mrg_prev_next = (best_reg != '0) && !prev_reg.used;
                    best_blk_next.used = 1'b0;
                    if (best_reg + CNT_W'(1) < cnt_reg)
                    begin
                        idx_next = best_reg + CNT_W'(1);
                        state_next = S_NEXT_RD;
                    end
                    else
                    begin
                        mrg_next_next = 1'b0;
                        state_next = S_MERGE;
                    end
                end
            end
            S_UP_RD:
            begin
                // allocate split: idx is the slot being filled
                if (idx_reg == best_reg + CNT_W'(1))
                begin
                    we = 1'b1;
                    waddr = idx_reg[IDX_W-1:0];
                    wdata = '{start: top_start, size: need[15:0], used: 1'b1};
                    gr_next = top_start + HEADER;
                    state_next = S_SPLIT;
                end
                else
                begin
                    raddr = IDX_W'(idx_reg - CNT_W'(1));
                    state_next = S_UP_WR;
                end
            end
            S_UP_WR:
            begin
                we = 1'b1;
                waddr = idx_reg[IDX_W-1:0];
                wdata = rdata;
                idx_next = idx_reg - CNT_W'(1);
                state_next = S_UP_RD;
            end
            S_SPLIT:
            begin
                // lower part stays free
                we = 1'b1;
                waddr = best_reg[IDX_W-1:0];
                wdata = '{start: best_blk_reg.start, size: remain, used: 1'b0};
                cnt_next = cnt_reg + CNT_W'(1);
                state_next = S_DONE;
            end
            S_NEXT_RD:
            begin
                state_next = S_NEXT;
            end
            S_NEXT:
            begin
                // fold a free successor into the freed block
                if (!rdata.used)
                begin
                    mrg_next_next = 1'b1;
                    best_blk_next.size = best_blk_reg.size + rdata.size;
                end
                else
                begin
                    mrg_next_next = 1'b0;
                end
                state_next = S_MERGE;
            end
            S_MERGE:
            begin
                // write merged entry, then close the gap of removed entries
                we = 1'b1;
                if (mrg_prev_reg)
                begin
                    waddr = IDX_W'(best_reg - CNT_W'(1));
                    wdata = '{start: prev_reg.start,
                              size: prev_reg.size + best_blk_reg.size, used: 1'b0};
                end
                else
                begin
                    waddr = best_reg[IDX_W-1:0];
                    wdata = best_blk_reg;
                end
                idx_next = src0;
                if (gap == 2'd0)
                begin
                    state_next = S_DONE;
                end
                else if (src0 >= cnt_reg)
                begin
                    cnt_next = cnt_reg - CNT_W'(gap);
                    state_next = S_DONE;
                end
                else
                begin
                    state_next = S_DN_RD;
                end
            end
            S_DN_RD:
            begin
                state_next = S_DN_WR;
            end
            S_DN_WR:
            begin
                we = 1'b1;
                waddr = IDX_W'(idx_reg - CNT_W'(gap));
                wdata = rdata;
                if (idx_reg + CNT_W'(1) >= cnt_reg)
                begin
                    cnt_next = cnt_reg - CNT_W'(gap);
                    state_next = S_DONE;
                end
                else
                begin
                    idx_next = idx_reg + CNT_W'(1);
                    state_next = S_DN_RD;
                end
            end
            S_DONE:
            begin
                rv_next = 1'b1;
                if (st_reg != ST_OK)
                begin
                    gr_next = '0;
                end
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // result held while waiting
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid && !rsp.ready |=> rsp.valid && $stable(rsp.status)
                                    && $stable(rsp.granted_offset));

    // no new transfer while a result is pending
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid |-> !req.ready);

    // table count stays in range
    a_count: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg >= CNT_W'(1) && cnt_reg <= CNT_W'(MAX_BLOCKS));

    // only defined status codes
    a_status: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid |-> (rsp.status == ST_OK || rsp.status == ST_FULL
                       || rsp.status == ST_NONE));

    // failed requests grant nothing
    a_grant_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid && rsp.status != ST_OK |-> rsp.granted_offset == 16'd0);
endmodule
